### src/deque_with_keyed_removal_unit_macros.svh
// Assertion macros for the deque RTL.
`ifndef DEQUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH
`define DEQUE_WITH_KEYED_REMOVAL_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define DWK_ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("dwk assertion failed: same-cycle implication");

`define DWK_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("dwk assertion failed: next-cycle implication");

`else

`define DWK_ASSERT_IMPLY(label, clk_s, rst_n_s, ante, cons)

`define DWK_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons)

`endif

`endif

### src/dwk_pkg.sv
`default_nettype none

package dwk_pkg;

	localparam int HANDLE_PORT_W = 32;
	localparam int COUNT_PORT_W  = 5;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_POP_HEAD = 2'd1,
		CMD_POP_TAIL = 2'd2,
		CMD_REMOVE   = 2'd3
	} dwk_cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} dwk_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} dwk_state_t;

endpackage

`default_nettype wire

### src/dwk_req_if.sv
`default_nettype none

interface dwk_req_if
	import dwk_pkg::*;
();

	logic                     valid;
	logic                     ready;
	dwk_cmd_t                 cmd;
	logic [HANDLE_PORT_W-1:0] handle;

	modport source (output valid, output cmd, output handle, input ready);
	modport sink (input valid, input cmd, input handle, output ready);

endinterface

`default_nettype wire

### src/dwk_rsp_if.sv
`default_nettype none

interface dwk_rsp_if
	import dwk_pkg::*;
();

	logic                     valid;
	logic                     ready;
	logic [HANDLE_PORT_W-1:0] out_handle;
	dwk_status_t              status;
	logic [COUNT_PORT_W-1:0]  entry_count;
	logic                     is_empty;

	modport source (
		output valid, output out_handle, output status, output entry_count, output is_empty,
		input ready
	);
	modport sink (
		input valid, input out_handle, input status, input entry_count, input is_empty,
		output ready
	);

endinterface

`default_nettype wire

### src/dwk_ram.sv
`default_nettype none

module dwk_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/deque_with_keyed_removal_unit.sv
// Bounded double-ended queue of handles with removal by key.
// req channel: one command per transfer (cmd, handle). rsp channel: one result per
// command (out_handle, status, entry_count, is_empty), held in an output register.
// Entries live in a single-port-write, single-port-read RAM used as a ring with a
// head pointer; one handle comparator is reused in every scan step.
// Steps from request transfer to result: push goes from decode to done; pop head or pop
// tail adds a pop step; remove on an empty queue goes from decode to done. Remove scans
// from the head until a match or the last entry, then shifts each later entry one slot
// toward the head; each scan or shift step is a read state and then a compare or write
// state, for the registered RAM read. The next request can be taken in the cycle after
// the result is loaded, i.e. one command at a time; a command in progress keeps
// req.ready low. When rsp.ready is low the result holds; a following command may still
// be taken and worked, and it waits in its last step until the output register frees.
// Reset (arst_n low) empties the queue and drops any pending result. RAM contents
// are not cleared; only data from slots below the entry count is ever used.
`include "deque_with_keyed_removal_unit_macros.svh"
`default_nettype none

module deque_with_keyed_removal_unit
	import dwk_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int HANDLE_W = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dwk_req_if.sink   req,
	dwk_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = CW + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);

	function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] base,
		input logic [CW-1:0] pos);
		logic [PW-1:0] sum;
		sum = PW'(base) + PW'(pos);
		if (sum >= DEPTH_P) begin
			sum = sum - DEPTH_P;
		end
		return sum[AW-1:0];
	endfunction

	dwk_state_t    state_q, state_d;
	dwk_cmd_t      cmd_q, cmd_d;
	logic [HANDLE_W-1:0] key_q, key_d;
	logic [HANDLE_W-1:0] res_q, res_d;
	dwk_status_t   status_q, status_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;

	logic                     out_valid_q, out_valid_d;
	logic                     out_load;
	logic [HANDLE_PORT_W-1:0] out_handle_q;
	dwk_status_t              out_status_q;
	logic [COUNT_PORT_W-1:0]  out_count_q;
	logic                     out_empty_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [HANDLE_W-1:0] ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [HANDLE_W-1:0] ram_rdata;
	logic [CW-1:0]       rpos;

	logic [63:0]         handle_ext;
	logic [63:0]         res_ext;
	logic [31:0]         count_ext;
	logic [HANDLE_W-1:0] key_in;
	logic [CW-1:0]       cnt_dec;
	logic [CW-1:0]       idx_inc;
	logic                cnt_zero;
	logic                cnt_full;
	logic                at_last;
	logic                hit;
	logic                out_free;

	assign handle_ext = 64'(req.handle);
	assign key_in     = handle_ext[HANDLE_W-1:0];
	assign res_ext    = 64'(res_q);
	assign count_ext  = 32'(count_q);
	assign cnt_dec    = count_q - 1'b1;
	assign idx_inc    = idx_q + 1'b1;
	assign cnt_zero   = (count_q == '0);
	assign cnt_full   = (count_q == FULL_CNT);
	assign at_last    = (idx_q == cnt_dec);
	assign hit        = (ram_rdata == key_q);
	assign out_free   = !out_valid_q || rsp.ready;
	assign ram_raddr  = slot_addr(head_q, rpos);

	dwk_ram #(
		.DEPTH (DEPTH),
		.WIDTH (HANDLE_W),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (cmd_q)
					CMD_PUSH:                   state_d = S_DONE;
					CMD_POP_HEAD, CMD_POP_TAIL: state_d = cnt_zero ? S_DONE : S_POP;
					CMD_REMOVE:                 state_d = cnt_zero ? S_DONE : S_SCAN_RD;
					default:                    state_d = S_DONE;
				endcase
			end
			S_POP:      state_d = S_DONE;
			S_SCAN_RD:  state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (at_last) begin
					state_d = S_DONE;
				end else if (hit) begin
					state_d = S_SHIFT_RD;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = (idx_inc == cnt_dec) ? S_DONE : S_SHIFT_RD;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_d       = cmd_q;
		key_d       = key_q;
		res_d       = res_q;
		status_d    = status_q;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		ram_we      = 1'b0;
		ram_waddr   = slot_addr(head_q, count_q);
		ram_wdata   = key_q;
		rpos        = idx_q;
		out_load    = 1'b0;
		out_valid_d = out_valid_q && !rsp.ready;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_d = req.cmd;
					key_d = key_in;
				end
			end
			S_DECODE: begin
				res_d    = '0;
				status_d = ST_OK;
				idx_d    = '0;
				case (cmd_q)
					CMD_PUSH: begin
						if (cnt_full) begin
							status_d = ST_FULL;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + 1'b1;
						end
					end
					CMD_POP_HEAD: begin
						rpos = '0;
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end
					end
					CMD_POP_TAIL: begin
						rpos = cnt_dec;
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end
					end
					CMD_REMOVE: begin
						rpos = '0;
						if (cnt_zero) begin
							status_d = ST_EMPTY;
						end
					end
					default: ;
				endcase
			end
			S_POP: begin
				res_d   = ram_rdata;
				count_d = cnt_dec;
				if (cmd_q == CMD_POP_HEAD) begin
					head_d = slot_addr(head_q, CW'(1));
				end
			end
			S_SCAN_RD: rpos = idx_q;
			S_SCAN_CMP: begin
				if (hit) begin
					res_d = key_q;
					if (at_last) begin
						count_d = cnt_dec;
					end
				end else begin
					idx_d = idx_inc;
					if (at_last) begin
						status_d = ST_NOT_FOUND;
					end
				end
			end
			S_SHIFT_RD: rpos = idx_inc;
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_addr(head_q, idx_q);
				ram_wdata = ram_rdata;
				idx_d     = idx_inc;
				if (idx_inc == cnt_dec) begin
					count_d = cnt_dec;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		key_q    <= key_d;
		res_q    <= res_d;
		status_q <= status_d;
		idx_q    <= idx_d;
		if (out_load) begin
			out_handle_q <= res_ext[HANDLE_PORT_W-1:0];
			out_status_q <= status_q;
			out_count_q  <= count_ext[COUNT_PORT_W-1:0];
			out_empty_q  <= cnt_zero;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.out_handle  = out_handle_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.is_empty    = out_empty_q;

	`DWK_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`DWK_ASSERT_IMPLY(a_empty_flag, clk, arst_n, rsp.valid && rsp.status == ST_EMPTY, rsp.is_empty)
	`DWK_ASSERT_IMPLY(a_full_count, clk, arst_n, out_load && status_q == ST_FULL, cnt_full)
	`DWK_ASSERT_IMPLY(a_scan_index, clk, arst_n, state_q == S_SCAN_CMP, idx_q < count_q)
	`DWK_ASSERT_NEXT(a_push_grows, clk, arst_n, state_q == S_DECODE && cmd_q == CMD_PUSH && !cnt_full, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
	import dwk_pkg::*;

	localparam int QDEPTH = 16;

	typedef struct packed {
		logic [HANDLE_PORT_W-1:0] out_handle;
		dwk_status_t              status;
		logic [COUNT_PORT_W-1:0]  entry_count;
		logic                     is_empty;
	} dwk_result_t;

	class deque_tracker;
		logic [HANDLE_PORT_W-1:0] held_handles[$];
		dwk_result_t              expected_results[$];
		int                       errors;

		function new();
			errors = 0;
		endfunction

		function void note_command(dwk_cmd_t c, logic [HANDLE_PORT_W-1:0] h);
			dwk_result_t r;
			int          hit;
			r.out_handle = '0;
			r.status     = ST_OK;
			hit          = -1;
			case (c)
				CMD_PUSH: begin
					if (held_handles.size() >= QDEPTH)
						r.status = ST_FULL;
					else
						held_handles.push_back(h);
				end
				CMD_POP_HEAD: begin
					if (held_handles.size() == 0)
						r.status = ST_EMPTY;
					else
						r.out_handle = held_handles.pop_front();
				end
				CMD_POP_TAIL: begin
					if (held_handles.size() == 0)
						r.status = ST_EMPTY;
					else
						r.out_handle = held_handles.pop_back();
				end
				default: begin
					if (held_handles.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						for (int i = 0; i < held_handles.size(); i++) begin
							if (hit < 0 && held_handles[i] == h)
								hit = i;
						end
						if (hit < 0) begin
							r.status = ST_NOT_FOUND;
						end else begin
							r.out_handle = h;
							held_handles.delete(hit);
						end
					end
				end
			endcase
			r.entry_count = COUNT_PORT_W'(held_handles.size());
			r.is_empty    = (held_handles.size() == 0);
			expected_results.push_back(r);
		endfunction

		function void check_result(dwk_result_t got);
			dwk_result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result handle=%h status=%0d count=%0d empty=%0b",
					$time, got.out_handle, got.status, got.entry_count, got.is_empty);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.out_handle !== want.out_handle) begin
				$display("%0t: out_handle expected %h actual %h",
					$time, want.out_handle, got.out_handle);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d",
					$time, want.entry_count, got.entry_count);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$display("%0t: is_empty expected %0b actual %0b",
					$time, want.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dwk_req_if req_ch ();
	dwk_rsp_if rsp_ch ();

	deque_with_keyed_removal_unit #(
		.DEPTH    (QDEPTH),
		.HANDLE_W (HANDLE_PORT_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_tracker tracker = new();
	bit           no_idle = 1'b0;
	int           gap_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_cycles();
		if (no_idle)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic logic [HANDLE_PORT_W-1:0] pick_handle();
		case ($urandom_range(0, 3))
			0, 1:    return HANDLE_PORT_W'($urandom_range(0, 7));
			2:       return $urandom;
			default: return ~HANDLE_PORT_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_command(dwk_cmd_t c, logic [HANDLE_PORT_W-1:0] h);
		if (gap_left > 0)
			repeat (gap_left) @(posedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.cmd    <= c;
		req_ch.handle <= h;
		do @(posedge clk); while (!req_ch.ready);
		tracker.note_command(c, h);
		gap_left = idle_cycles();
		if (gap_left > 0)
			req_ch.valid <= 1'b0;
	endtask

	task automatic hold_until_drained();
		if (gap_left == 0)
			req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		gap_left = 0;
	endtask

	task automatic run_directed();
		send_command(CMD_POP_HEAD, 32'h0000_0000);
		send_command(CMD_POP_TAIL, 32'hFFFF_FFFF);
		send_command(CMD_REMOVE, 32'h0000_0000);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_REMOVE, 32'h0000_0000);
		send_command(CMD_REMOVE, 32'h1234_5678);
		send_command(CMD_REMOVE, 32'h0000_0000);
		send_command(CMD_POP_HEAD, 32'h0000_0000);
		for (int i = 0; i < QDEPTH; i++)
			send_command(CMD_PUSH, (i % 2) ? (32'h5A5A_5A50 | i) : (32'hA5A5_A5A0 | i));
		send_command(CMD_PUSH, 32'hDEAD_BEEF);
		send_command(CMD_REMOVE, 32'h5A5A_5A5F);
		send_command(CMD_POP_TAIL, 32'h0000_0000);
	endtask

	task automatic run_segment(int n, int push_weight);
		int                       r;
		dwk_cmd_t                 c;
		logic [HANDLE_PORT_W-1:0] h;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			h = pick_handle();
			if (r < push_weight) begin
				c = CMD_PUSH;
			end else begin
				c = dwk_cmd_t'($urandom_range(1, 3));
				if (c == CMD_REMOVE && tracker.held_handles.size() != 0
					&& $urandom_range(0, 2) != 0)
					h = tracker.held_handles[$urandom_range(0, tracker.held_handles.size() - 1)];
			end
			send_command(c, h);
		end
	endtask

	initial begin
		int weights[10];
		int waited;
		weights = '{85, 50, 15, 90, 10, 50, 70, 30, 95, 5};
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = CMD_PUSH;
		req_ch.handle = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		hold_until_drained();
		for (int s = 0; s < 10; s++) begin
			no_idle = (s == 2) || ($urandom_range(0, 3) == 0);
			run_segment(40, weights[s]);
			if (s % 3 == 0)
				hold_until_drained();
		end
		no_idle = 1'b0;
		hold_until_drained();
		waited = 0;
		while (tracker.expected_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (tracker.expected_results.size() != 0)
				$display("%0t: %0d results never arrived", $time,
					tracker.expected_results.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		int          stall;
		dwk_result_t got;
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got = '{rsp_ch.out_handle, rsp_ch.status, rsp_ch.entry_count, rsp_ch.is_empty};
			tracker.check_result(got);
		end
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/dwk_pkg.sv
src/dwk_req_if.sv
src/dwk_rsp_if.sv
src/dwk_ram.sv
src/deque_with_keyed_removal_unit.sv
tb/sv/tb.sv
